### hw/rtl/ddm_pkg.sv
package ddm_pkg;

    // event kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_PRESS_A = 2'd0,
        KIND_PRESS_B = 2'd1,
        KIND_REDRAW  = 2'd2
    } kind_t;

    // register indexes, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LIT_COLOR  = 2'd1,
        REG_BRIGHTNESS = 2'd2
    } reg_idx_t;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd300;
    localparam logic [23:0] LIT_COLOR_RST  = 24'h0000FF;
    localparam logic [8:0]  BRIGHTNESS_RST = 9'd230;

    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [2:0] GRID_LAST  = 3'd4;
    localparam logic [4:0] PIXEL_LAST = 5'd24;

    // font row of a digit, bit 4 is the leftmost column, row 0 on top
    function automatic logic [4:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
        logic [24:0] rows;
        begin
            unique case (digit)
                4'd0:    rows = {5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E};
                4'd1:    rows = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E};
                4'd2:    rows = {5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E};
                4'd3:    rows = {5'h0E, 5'h02, 5'h0E, 5'h02, 5'h0E};
                4'd4:    rows = {5'h0A, 5'h0A, 5'h0E, 5'h02, 5'h08};
                4'd5:    rows = {5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E};
                4'd6:    rows = {5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E};
                4'd7:    rows = {5'h0E, 5'h02, 5'h04, 5'h04, 5'h04};
                4'd8:    rows = {5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E};
                4'd9:    rows = {5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h08};
                default: rows = 25'd0;
            endcase
            case (row)
                3'd0:    glyph_row = rows[24:20];
                3'd1:    glyph_row = rows[19:15];
                3'd2:    glyph_row = rows[14:10];
                3'd3:    glyph_row = rows[9:5];
                3'd4:    glyph_row = rows[4:0];
                default: glyph_row = 5'd0;
            endcase
        end
    endfunction

    // one color byte times brightness / 256, saturating at 255
    function automatic logic [7:0] scale_byte(input logic [7:0] b, input logic [8:0] q8);
        logic [16:0] prod;
        begin
            prod = {9'd0, b} * {8'd0, q8};
            scale_byte = prod[16] ? 8'hFF : prod[15:8];
        end
    endfunction

endpackage

### hw/rtl/ddm_front.sv
module ddm_front
    import ddm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] now_ms,
    input  logic [1:0]  kind,
    input  logic [15:0] debounce_ms,
    input  logic        q_full,
    output logic        q_push,
    output logic [3:0]  q_digit
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    logic [3:0]    digit_reg, digit_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   last_a_reg, last_a_next;
    logic [31:0]   last_b_reg, last_b_next;
    logic [3:0]    top_reg, top_next;
    logic          refill_reg, refill_next;
    logic [3:0]    rd_data_reg;
    logic [3:0]    hist_mem [HISTORY_DEPTH];

    logic          accept;
    logic [31:0]   elapsed_a, elapsed_b;
    logic          pass_a, pass_b;
    logic [3:0]    top_val;
    logic          mem_we;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [CW-1:0] count_m2;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // debounce checks, wrapping difference
    assign elapsed_a = now_ms - last_a_reg;
    assign elapsed_b = now_ms - last_b_reg;
    assign pass_a    = elapsed_a > {16'd0, debounce_ms};
    assign pass_b    = elapsed_b > {16'd0, debounce_ms};

    // top of stack, from the read port just after a pop
    assign top_val  = refill_reg ? rd_data_reg : top_reg;
    assign count_m2 = count_reg - CW'(2);
    assign wr_addr  = count_reg[AW-1:0];

    // event handling
    always_comb
    begin
        digit_next  = digit_reg;
        count_next  = count_reg;
        last_a_next = last_a_reg;
        last_b_next = last_b_reg;
        top_next    = top_val;
        refill_next = 1'b0;
        mem_we      = 1'b0;
        rd_addr     = '0;
        q_push      = 1'b0;
        q_digit     = digit_reg;
        if (accept)
        begin
            case (kind_t'(kind))
                KIND_PRESS_A:
                begin
                    if (pass_a)
                    begin
                        last_a_next = now_ms;
                        if (count_reg < DEPTH_C)
                        begin
                            mem_we     = 1'b1;
                            top_next   = digit_reg;
                            count_next = count_reg + CW'(1);
                        end
                        digit_next = (digit_reg == DIGIT_MAX) ? 4'd0 : digit_reg + 4'd1;
                        q_push     = 1'b1;
                        q_digit    = digit_next;
                    end
                end
                KIND_PRESS_B:
                begin
                    if (pass_b)
                    begin
                        last_b_next = now_ms;
                        if (count_reg != '0)
                        begin
                            count_next  = count_reg - CW'(1);
                            digit_next  = top_val;
                            refill_next = 1'b1;
                            if (count_reg > CW'(1))
                                rd_addr = count_m2[AW-1:0];
                            q_push  = 1'b1;
                            q_digit = top_val;
                        end
                    end
                end
                KIND_REDRAW:
                begin
                    q_push  = 1'b1;
                    q_digit = digit_reg;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // history stack storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[wr_addr] <= digit_reg;
        rd_data_reg <= hist_mem[rd_addr];
    end

    // control and timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg  <= 4'd0;
            count_reg  <= '0;
            last_a_reg <= 32'd0;
            last_b_reg <= 32'd0;
            refill_reg <= 1'b0;
        end
        else
        begin
            digit_reg  <= digit_next;
            count_reg  <= count_next;
            last_a_reg <= last_a_next;
            last_b_reg <= last_b_next;
            refill_reg <= refill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

endmodule

### hw/rtl/ddm_queue.sv
module ddm_queue
    import ddm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [3:0] push_digit,
    input  logic       pop,
    output logic       full,
    output logic       empty,
    output logic [3:0] head_digit
);

    logic [3:0] slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = count_reg == 2'd2;
    assign empty      = count_reg == 2'd0;
    assign head_digit = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    // frame request slots
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/ddm_back.sv
module ddm_back
    import ddm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  logic [3:0]  q_head,
    output logic        q_pop,
    input  logic [23:0] dim_color,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    logic        busy_reg, busy_next;
    logic [3:0]  digit_reg, digit_next;
    logic [2:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;
    logic [4:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [4:0]  out_idx_reg;
    logic [23:0] out_color_reg;
    logic        out_last_reg;

    logic        out_free, emit, at_end, load;
    logic [4:0]  font_bits;
    logic        lit;

    assign out_free = !valid_reg || m_tready;
    assign emit     = out_free && busy_reg;
    assign at_end   = idx_reg == PIXEL_LAST;
    assign load     = out_free && !q_empty && (!busy_reg || at_end);
    assign q_pop    = load;

    // rows are drawn bottom up from the font
    assign font_bits = glyph_row(digit_reg, GRID_LAST - row_reg);
    assign lit       = font_bits[GRID_LAST - col_reg];

    // pixel walk
    always_comb
    begin
        busy_next  = busy_reg;
        digit_next = digit_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (out_free)
            valid_next = emit;
        if (emit)
        begin
            idx_next = idx_reg + 5'd1;
            if (col_reg == GRID_LAST)
            begin
                col_next = 3'd0;
                row_next = row_reg + 3'd1;
            end
            else
            begin
                col_next = col_reg + 3'd1;
            end
            if (at_end)
                busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next  = 1'b1;
            digit_next = q_head;
            row_next   = 3'd0;
            col_next   = 3'd0;
            idx_next   = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            row_reg   <= 3'd0;
            col_reg   <= 3'd0;
            idx_reg   <= 5'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        if (emit)
        begin
            out_idx_reg   <= idx_reg;
            out_color_reg <= lit ? dim_color : 24'd0;
            out_last_reg  <= at_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, out_color_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/debounced_digit_matrix_driver_unit.sv
// Digit display driver for a 5x5 pixel chain. Input beats carry an event kind
// in tuser (press A, press B, redraw) and a millisecond timestamp in tdata;
// presses no more than debounce_ms after the last accepted press of the same
// button are ignored. Press A pushes the shown digit on a history stack when
// it has room and advances it, press B pops it back; every accepted press that
// changes the digit, and every redraw, yields one frame of 25 pixel beats,
// index 0 to 24, tlast on the last. One pixel leaves per cycle while m_tready
// is high, from the pixel counter in the output stage, and queued frames follow
// without a gap; the first pixel passes the frame queue, the pixel walk and the
// output beat register. Event beats are taken one per cycle while the two-entry
// frame queue has room, so up to two frames can wait behind the one on the wire.
module debounced_digit_matrix_driver_unit
    import ddm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
)(
    input  logic        clk,
    input  logic        rst_n,
    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] now_ms
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // pixel output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] pixel_index, [28:5] pixel_color, rest zero
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] debounce_reg;
    logic [23:0] color_reg;
    logic [8:0]  bright_reg;
    logic [23:0] dim_reg;
    logic        cfg_write;
    reg_idx_t    reg_sel;

    logic        q_full, q_empty, q_push, q_pop;
    logic [3:0]  q_digit, q_head;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            color_reg    <= LIT_COLOR_RST;
            bright_reg   <= BRIGHTNESS_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_DEBOUNCE:   debounce_reg <= pwdata[15:0];
                REG_LIT_COLOR:  color_reg    <= pwdata[23:0];
                REG_BRIGHTNESS: bright_reg   <= pwdata[8:0];
                default:        debounce_reg <= debounce_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_sel)
            REG_DEBOUNCE:   prdata = {16'd0, debounce_reg};
            REG_LIT_COLOR:  prdata = {8'd0, color_reg};
            REG_BRIGHTNESS: prdata = {23'd0, bright_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // dimmed lit color, follows the registers
    always_ff @(posedge clk)
    begin
        dim_reg <= {scale_byte(color_reg[23:16], bright_reg),
                    scale_byte(color_reg[15:8], bright_reg),
                    scale_byte(color_reg[7:0], bright_reg)};
    end

    ddm_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .now_ms      (s_tdata),
        .kind        (s_tuser),
        .debounce_ms (debounce_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_digit     (q_digit)
    );

    ddm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_digit (q_digit),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head_digit (q_head)
    );

    ddm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .dim_color (dim_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // last beat sits on pixel 24 and nowhere else
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[4:0] == PIXEL_LAST)))
        else $error("tlast out of place");

    // inside a frame the next pixel follows at once
    a_frame_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a frame");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tdata[4:0] == $past(m_tdata[4:0]) + 5'd1)
        else $error("pixel index skipped");

    // pixels are either dark or the dimmed color
    a_color_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[28:5] == 24'd0 || m_tdata[28:5] == dim_reg))
        else $error("unexpected pixel color");

endmodule
